// File: sv/qss_pkg.sv
`timescale 1ns / 1ps
package qss_pkg;
    localparam int DATA_W = 32;

    // Read address source for the item store.
    typedef enum logic [2:0] {
        RD_EMIT, RD_MID, RD_HI, RD_J, RD_I
    } rd_sel_t;

    // Write address and data source for the item store.
    typedef enum logic [2:0] {
        WR_NONE, WR_HI_PIVOT, WR_MID_TMP, WR_J_RD, WR_I_TMP, WR_I_PIVOT, WR_HI_TMP
    } wr_sel_t;

    typedef struct packed {
        logic    store_item;
        logic    stack_init;
        logic    pop;
        logic    load_range;
        logic    load_pivot;
        logic    load_tmp;
        logic    init_scan;
        logic    inc_i;
        logic    inc_j;
        logic    push_right;
        logic    push_left;
        logic    emit_init;
        logic    emit_load;
        logic    emit_next;
        logic    clear_count;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
    } qss_cmd_t;

    typedef struct packed {
        logic item_room;
        logic few_items;
        logic stack_empty;
        logic range_empty;
        logic scan_end;
        logic less_pivot;
        logic i_eq_j;
        logic right_push;
        logic left_push;
        logic emit_last;
    } qss_stat_t;
endpackage

// File: sv/qss_ctrl.sv
`timescale 1ns / 1ps
module qss_ctrl
    import qss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  logic      in_last,
    input  logic      out_fire,
    input  qss_stat_t stat,
    output logic      accept_ok,
    output qss_cmd_t  cmd
);
    typedef enum logic [4:0] {
        ST_LOAD, ST_START, ST_POP, ST_RANGE, ST_MID_A, ST_MID_B, ST_MID_C, ST_MID_D,
        ST_SCAN, ST_CMP, ST_SWAP_A, ST_SWAP_B, ST_FIN_A, ST_FIN_B, ST_FIN_C,
        ST_PUSH_R, ST_PUSH_L, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
    } state_t;
    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        accept_ok  = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                accept_ok      = 1'b1;
                cmd.store_item = in_fire && stat.item_room;
                if (in_fire && in_last) state_next = ST_START;
            end
            ST_START: begin
                if (stat.few_items) begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end else begin
                    cmd.stack_init = 1'b1;
                    state_next     = ST_POP;
                end
            end
            ST_POP: begin
                if (stat.stack_empty) begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                cmd.load_range = 1'b1;
                state_next     = stat.range_empty ? ST_POP : ST_MID_A;
            end
            ST_MID_A: begin
                cmd.rd_sel = RD_MID;
                state_next = ST_MID_B;
            end
            ST_MID_B: begin
                cmd.rd_sel     = RD_HI;
                cmd.load_pivot = 1'b1;
                state_next     = ST_MID_C;
            end
            ST_MID_C: begin
                cmd.load_tmp = 1'b1;
                cmd.wr_sel   = WR_HI_PIVOT;
                state_next   = ST_MID_D;
            end
            ST_MID_D: begin
                cmd.wr_sel    = WR_MID_TMP;
                cmd.init_scan = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.rd_sel = RD_J;
                state_next = stat.scan_end ? ST_FIN_A : ST_CMP;
            end
            ST_CMP: begin
                cmd.rd_sel = RD_I;
                if (stat.less_pivot && stat.i_eq_j) begin
                    cmd.inc_i  = 1'b1;
                    cmd.inc_j  = 1'b1;
                    state_next = ST_SCAN;
                end else if (stat.less_pivot) begin
                    cmd.load_tmp = 1'b1;
                    state_next   = ST_SWAP_A;
                end else begin
                    cmd.inc_j  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SWAP_A: begin
                cmd.wr_sel = WR_J_RD;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                cmd.wr_sel = WR_I_TMP;
                cmd.inc_i  = 1'b1;
                cmd.inc_j  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_FIN_A: begin
                cmd.rd_sel = RD_I;
                state_next = ST_FIN_B;
            end
            ST_FIN_B: begin
                cmd.load_tmp = 1'b1;
                cmd.wr_sel   = WR_I_PIVOT;
                state_next   = ST_FIN_C;
            end
            ST_FIN_C: begin
                cmd.wr_sel = WR_HI_TMP;
                state_next = ST_PUSH_R;
            end
            ST_PUSH_R: begin
                cmd.push_right = stat.right_push;
                state_next     = ST_PUSH_L;
            end
            ST_PUSH_L: begin
                cmd.push_left = stat.left_push;
                state_next    = ST_POP;
            end
            ST_EMIT_RD: begin
                cmd.rd_sel = RD_EMIT;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                cmd.emit_load = 1'b1;
                state_next    = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (out_fire) begin
                    cmd.emit_next = 1'b1;
                    if (stat.emit_last) begin
                        cmd.clear_count = 1'b1;
                        state_next      = ST_LOAD;
                    end else begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// File: sv/qss_dp.sv
`timescale 1ns / 1ps
module qss_dp
    import qss_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  qss_cmd_t                 cmd,
    input  logic signed [DATA_W-1:0] in_value,
    output qss_stat_t                stat,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] out_value,
    output logic                     out_final
);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic signed [DATA_W-1:0] mem [MAX_ITEMS];
    logic [2*IW-1:0]          stk [MAX_ITEMS];

    logic [CW-1:0]            count_reg, sp_reg, emit_idx_reg;
    logic [IW-1:0]            lo_reg, hi_reg, i_reg, j_reg;
    logic signed [DATA_W-1:0] pivot_reg, tmp_reg, rd_reg, ovv_reg;
    logic [2*IW-1:0]          stk_rd_reg;
    logic                     ov_reg, of_reg;

    logic [IW:0]              mid_sum, i_plus1, lo_plus1;
    logic [IW-1:0]            mid_idx, rd_addr, wr_addr, stk_ra;
    logic                     wr_en;
    logic signed [DATA_W-1:0] wr_data;
    logic                     stk_push;
    logic [2*IW-1:0]          stk_wd;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_idx  = mid_sum[IW:1];
    assign i_plus1  = {1'b0, i_reg} + (IW+1)'(1);
    assign lo_plus1 = {1'b0, lo_reg} + (IW+1)'(1);
    assign stk_ra   = IW'(sp_reg - CW'(1));
    assign stk_push = (cmd.push_right || cmd.push_left) && (sp_reg < CW'(MAX_ITEMS));
    assign stk_wd   = cmd.push_right ? {i_plus1[IW-1:0], hi_reg}
                                     : {lo_reg, i_reg - IW'(1)};

    always_comb begin
        case (cmd.rd_sel)
            RD_MID:  rd_addr = mid_idx;
            RD_HI:   rd_addr = hi_reg;
            RD_J:    rd_addr = j_reg;
            RD_I:    rd_addr = i_reg;
            RD_EMIT: rd_addr = emit_idx_reg[IW-1:0];
            default: rd_addr = emit_idx_reg[IW-1:0];
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = i_reg;
        wr_data = pivot_reg;
        case (cmd.wr_sel)
            WR_NONE: begin
                wr_en   = cmd.store_item;
                wr_addr = count_reg[IW-1:0];
                wr_data = in_value;
            end
            WR_HI_PIVOT: begin
                wr_addr = hi_reg;
                wr_data = pivot_reg;
            end
            WR_MID_TMP: begin
                wr_addr = mid_idx;
                wr_data = tmp_reg;
            end
            WR_J_RD: begin
                wr_addr = j_reg;
                wr_data = rd_reg;
            end
            WR_I_TMP: begin
                wr_addr = i_reg;
                wr_data = tmp_reg;
            end
            WR_I_PIVOT: begin
                wr_addr = i_reg;
                wr_data = pivot_reg;
            end
            WR_HI_TMP: begin
                wr_addr = hi_reg;
                wr_data = tmp_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Item store: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    // Range stack: the top entry is read every cycle, ready just after a pop.
    always_ff @(posedge aclk) begin
        stk_rd_reg <= stk[stk_ra];
        if (cmd.stack_init) stk[0] <= {IW'(0), IW'(count_reg - CW'(1))};
        else if (stk_push) stk[sp_reg[IW-1:0]] <= stk_wd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            sp_reg       <= '0;
            emit_idx_reg <= '0;
            ov_reg       <= 1'b0;
        end else begin
            if (cmd.store_item) count_reg <= count_reg + CW'(1);
            else if (cmd.clear_count) count_reg <= '0;
            if (cmd.stack_init) sp_reg <= CW'(1);
            else if (cmd.pop) sp_reg <= sp_reg - CW'(1);
            else if (stk_push) sp_reg <= sp_reg + CW'(1);
            if (cmd.emit_init) emit_idx_reg <= '0;
            else if (cmd.emit_next) emit_idx_reg <= emit_idx_reg + CW'(1);
            if (cmd.emit_load) ov_reg <= 1'b1;
            else if (cmd.emit_next) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_range) begin
            lo_reg <= stk_rd_reg[2*IW-1:IW];
            hi_reg <= stk_rd_reg[IW-1:0];
        end
        if (cmd.init_scan) begin
            i_reg <= lo_reg;
            j_reg <= lo_reg;
        end else begin
            if (cmd.inc_i) i_reg <= i_reg + IW'(1);
            if (cmd.inc_j) j_reg <= j_reg + IW'(1);
        end
        if (cmd.load_pivot) pivot_reg <= rd_reg;
        if (cmd.load_tmp) tmp_reg <= rd_reg;
        if (cmd.emit_load) begin
            ovv_reg <= rd_reg;
            of_reg  <= stat.emit_last;
        end
    end

    always_comb begin
        stat.item_room   = (count_reg < CW'(MAX_ITEMS));
        stat.few_items   = (count_reg < CW'(2));
        stat.stack_empty = (sp_reg == '0);
        stat.range_empty = (stk_rd_reg[IW-1:0] <= stk_rd_reg[2*IW-1:IW]);
        stat.scan_end    = (j_reg == hi_reg);
        stat.less_pivot  = (rd_reg < pivot_reg);
        stat.i_eq_j      = (i_reg == j_reg);
        stat.right_push  = (i_plus1 < {1'b0, hi_reg});
        stat.left_push   = ({1'b0, i_reg} > lo_plus1);
        stat.emit_last   = ((emit_idx_reg + CW'(1)) == count_reg);
    end

    assign out_valid = ov_reg;
    assign out_value = ovv_reg;
    assign out_final = of_reg;
endmodule

// File: sv/quicksort_sorter_unit.sv
`timescale 1ns / 1ps
// Quicksort sorter: words are loaded one per cycle, up to MAX_ITEMS of them (further
// words are dropped); the word with s_axis_tlast closes the list, which is then
// sorted in place (Lomuto partition, middle pivot, explicit range stack) and
// emitted ascending with m_axis_tlast on the largest value. For each popped range,
// sorting swaps the middle word to the top as pivot, compares each element with
// it, swapping smaller ones down, places the pivot and pushes the subranges; on
// average there are about n log n compares. Each output word is read and held
// until m_axis_tready takes it, and only then is the next word read. Input
// is not accepted from the closing word until the final sorted word is taken.
module quicksort_sorter_unit
    import qss_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sorted_value
    output logic        m_axis_tlast
);
    logic      in_fire, out_fire, acc_ok;
    qss_cmd_t  cmd;
    qss_stat_t stat;

    assign s_axis_tready = acc_ok;
    assign in_fire  = s_axis_tvalid && acc_ok;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    qss_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_last(s_axis_tlast),
        .out_fire(out_fire), .stat(stat), .accept_ok(acc_ok), .cmd(cmd)
    );

    qss_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_value(s_axis_tdata),
        .stat(stat), .out_valid(m_axis_tvalid), .out_value(m_axis_tdata),
        .out_final(m_axis_tlast)
    );
endmodule
